[design/sttb_pkg.sv]
// Shared types and constants for the software timer table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sttb_pkg;

  localparam int NumTimersDef = 32;
  localparam int MaxOut       = 32;
  localparam int PeriodW      = 32;
  localparam int SlotW        = 5;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_SET_OK   = 2'd0,
    KIND_SET_FULL = 2'd1,
    KIND_FIRED    = 2'd2
  } kind_e;

  // one stored slot entry
  typedef struct packed {
    logic               rep_flag;
    logic [PeriodW-1:0] count;
    logic [PeriodW-1:0] period;
  } slot_word_t;

  localparam int SlotWordW = $bits(slot_word_t);

endpackage

[design/sttb_slot_ram.sv]
// Slot storage: period, counter and repeat flag, one word per slot.
// Single address port, registered read data. Uses sttb_pkg.
`timescale 1ns / 1ps

module sttb_slot_ram
  import sttb_pkg::*;
#(
  parameter int Depth = NumTimersDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  slot_word_t       wdata_i,
  output slot_word_t       rdata_o
);

  slot_word_t mem [Depth];
  slot_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sttb_tick_alu.sv]
// Shared tick unit: increments one slot counter and compares it to the period.
// Uses sttb_pkg for field widths.
`timescale 1ns / 1ps

module sttb_tick_alu
  import sttb_pkg::*;
(
  input  logic [PeriodW-1:0] count_i,
  input  logic [PeriodW-1:0] period_i,
  output logic [PeriodW-1:0] count_next_o,
  output logic               fire_o
);

  logic [PeriodW-1:0] count_inc;

  assign count_inc    = count_i + PeriodW'(1);
  assign fire_o       = (count_inc >= period_i);
  assign count_next_o = fire_o ? '0 : count_inc;

endmodule

[design/software_timer_table.sv]
// Top level of the software timer table: sequencer, armed flags, output register.
// Depends on sttb_pkg, sttb_slot_ram and sttb_tick_alu.
`timescale 1ns / 1ps

// Usage
//   Commands come in on the s_axis channel: tuser carries the op (set, cancel,
//   tick), tdata the period, repeat flag and timer id. Results leave on m_axis:
//   tuser is the result kind, tdata the slot number, tlast marks the final
//   result of a command.
//   Set walks the armed flags from slot 0, one slot per cycle, and answers with
//   one result for the lowest free slot, or a full result when no slot is free.
//   Cancel gives no result.
//   Tick walks every slot through the one shared increment/compare unit:
//   a free slot is passed over, an armed slot takes a memory read and then an
//   update, and a final flush step delivers the last pending result, if any.
//   Fired slots come out in ascending order.
//   The block takes no new command while a command is in progress.
//   Reset clears all armed flags at once (every slot free); no clearing pass.
//   When the receiver stalls, the walk waits at the next result to deliver;
//   one result is held in the output register, one more in a pending slot.
//   Unused op codes are dropped.

module software_timer_table
  import sttb_pkg::*;
#(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // period[31:0], repeat_req[32], timer_id[37:33]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // slot[4:0]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o
);

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RepW = $clog2(MaxOut + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_TICK_RD,
    ST_TICK_EX,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     idx_q;
  logic [NUM_TIMERS-1:0] armed_q;
  logic [PeriodW-1:0]  set_period_q;
  logic                set_rep_q;
  logic                pend_v_q;
  logic [IdxW-1:0]     pend_idx_q;
  logic [RepW-1:0]     reported_q;
  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [SlotW-1:0]    out_slot_q;
  logic                out_last_q;

  // input fields
  logic [PeriodW-1:0]  in_period;
  logic                in_rep;
  logic [SlotW-1:0]    in_id;
  logic                in_xfer;
  logic [IdxW+SlotW-1:0] id_ext;
  logic [IdxW-1:0]     cancel_idx;
  logic                cancel_ok;

  assign in_period  = s_axis_tdata_i[31:0];
  assign in_rep     = s_axis_tdata_i[32];
  assign in_id      = s_axis_tdata_i[37:33];
  assign id_ext     = {{IdxW{1'b0}}, in_id};
  assign cancel_idx = id_ext[IdxW-1:0];
  assign cancel_ok  = (32'(in_id) < NUM_TIMERS);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // slot number masked to the result field width
  function automatic logic [SlotW-1:0] slot_of(input logic [IdxW-1:0] idx);
    logic [IdxW+SlotW-1:0] ext;
    ext = {{SlotW{1'b0}}, idx};
    return ext[SlotW-1:0];
  endfunction

  // memory and shared unit
  logic               ram_we;
  logic               ram_re;
  slot_word_t         ram_wdata;
  slot_word_t         ram_rdata;
  logic [PeriodW-1:0] alu_count_next;
  logic               alu_fire;

  sttb_slot_ram #(
    .Depth (NUM_TIMERS),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (idx_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sttb_tick_alu u_tick_alu (
    .count_i      (ram_rdata.count),
    .period_i     (ram_rdata.period),
    .count_next_o (alu_count_next),
    .fire_o       (alu_fire)
  );

  logic out_free;
  logic slot_armed;
  logic capture;
  logic ex_stall;
  logic out_load;

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign slot_armed = armed_q[idx_q];
  assign capture    = (reported_q < RepW'(MaxOut));
  assign ex_stall   = alu_fire && capture && pend_v_q && !out_free;

  // a new result enters the output register this cycle
  assign out_load = ((state_q == ST_SET) && out_free && (!slot_armed || (idx_q == LastIdx)))
                 || ((state_q == ST_TICK_EX) && !ex_stall && alu_fire && capture && pend_v_q)
                 || ((state_q == ST_FLUSH) && pend_v_q && out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;
    case (state_q)
      ST_SET: begin
        if (!slot_armed && out_free) begin
          ram_we             = 1'b1;
          ram_wdata.rep_flag = set_rep_q;
          ram_wdata.count    = '0;
          ram_wdata.period   = set_period_q;
        end
      end
      ST_TICK_RD: begin
        ram_re = slot_armed;
      end
      ST_TICK_EX: begin
        if (!ex_stall) begin
          ram_we          = 1'b1;
          ram_wdata.count = alu_count_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      armed_q     <= '0;
      pend_v_q    <= 1'b0;
      reported_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_q        <= '0;
            set_period_q <= in_period;
            set_rep_q    <= in_rep;
            case (op_e'(s_axis_tuser_i))
              OP_SET: state_q <= ST_SET;
              OP_CANCEL: begin
                if (cancel_ok) begin
                  armed_q[cancel_idx] <= 1'b0;
                end
              end
              OP_TICK: begin
                reported_q <= '0;
                pend_v_q   <= 1'b0;
                state_q    <= ST_TICK_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SET: begin
          if (!slot_armed) begin
            if (out_free) begin
              armed_q[idx_q] <= (set_period_q != '0);
              out_kind_q     <= KIND_SET_OK;
              out_slot_q     <= slot_of(idx_q);
              out_last_q     <= 1'b1;
              state_q        <= ST_IDLE;
            end
          end else if (idx_q == LastIdx) begin
            if (out_free) begin
              out_kind_q  <= KIND_SET_FULL;
              out_slot_q  <= '0;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_TICK_RD: begin
          if (slot_armed) begin
            state_q <= ST_TICK_EX;
          end else if (idx_q == LastIdx) begin
            state_q <= ST_FLUSH;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_TICK_EX: begin
          if (!ex_stall) begin
            if (alu_fire && !ram_rdata.rep_flag) begin
              armed_q[idx_q] <= 1'b0;
            end
            if (alu_fire && capture) begin
              // previous fired slot goes out; this one waits for the next
              if (pend_v_q) begin
                out_kind_q  <= KIND_FIRED;
                out_slot_q  <= slot_of(pend_idx_q);
                out_last_q  <= 1'b0;
              end
              pend_v_q   <= 1'b1;
              pend_idx_q <= idx_q;
              reported_q <= reported_q + RepW'(1);
            end
            if (idx_q == LastIdx) begin
              state_q <= ST_FLUSH;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= ST_TICK_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_kind_q  <= KIND_FIRED;
            out_slot_q  <= slot_of(pend_idx_q);
            out_last_q  <= 1'b1;
            pend_v_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
